[hdl/edge_normalized_image_blur_top_assert.svh]
// Assertion macros for the blur block.
`ifndef EDGE_NORMALIZED_IMAGE_BLUR_TOP_ASSERT_SVH
`define EDGE_NORMALIZED_IMAGE_BLUR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ENB_ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define ENB_ASSERT_NEXT(label, cond, expect_next, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expect_next)) \
        else $error(msg);
`else
`define ENB_ASSERT_IMPL(label, prop, msg)
`define ENB_ASSERT_NEXT(label, cond, expect_next, msg)
`endif
`endif

[hdl/enb_pkg.sv]
`timescale 1ns / 1ps
package enb_pkg;
    localparam int MaxKernel = 15;
    localparam int MaxWidth = 256;
    localparam int MaxHeight = 256;
    localparam int KwDepth = MaxKernel * MaxKernel;
    localparam int PixDepth = (MaxWidth * MaxHeight < 65536) ? MaxWidth * MaxHeight : 65536;
    localparam int KwAw = $clog2(KwDepth);
    localparam int PixAw = $clog2(PixDepth);
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 9;

    localparam logic [1:0] MODE_WEIGHT = 2'd0;
    localparam logic [1:0] MODE_PIXEL = 2'd1;
    localparam logic [1:0] MODE_BLUR = 2'd2;

    localparam logic [CfgIdxW-1:0] REG_KSIZE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_WIDTH = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_HEIGHT = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_CHANS = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] index;
        logic [15:0] weight_value;
        logic [7:0]  in_chan0;
        logic [7:0]  in_chan1;
        logic [7:0]  in_chan2;
        logic [7:0]  in_chan3;
    } enb_in_t;

    typedef struct packed {
        logic [15:0] pixel_number;
        logic [7:0]  out_chan0;
        logic [7:0]  out_chan1;
        logic [7:0]  out_chan2;
        logic [7:0]  out_chan3;
        logic        no_weight_seen;
    } enb_out_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_req;
        logic wr_weight;
        logic wr_pixel;
        logic tap_start;
        logic tap_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } enb_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic tap_last;
        logic div_last;
    } enb_sts_t;
endpackage

[hdl/enb_ctrl.sv]
`timescale 1ns / 1ps
`include "edge_normalized_image_blur_top_assert.svh"
module enb_ctrl
    import enb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    output logic       m_valid,
    input  logic       m_ready,
    output enb_cmd_t   cmd,
    input  enb_sts_t   sts
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV0, ST_TAP, ST_DRAIN, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_req = 1'b1;
                    cmd.wr_weight = (s_mode == MODE_WEIGHT);
                    cmd.wr_pixel = (s_mode == MODE_PIXEL);
                    if (s_mode == MODE_BLUR) begin
                        state_next = ST_DIV0;
                    end
                end
            end
            ST_DIV0: begin
                cmd.tap_start = 1'b1;
                state_next = ST_TAP;
            end
            ST_TAP: begin
                cmd.tap_step = 1'b1;
                if (sts.tap_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ENB_ASSERT_NEXT(a_out_held, m_valid && !m_ready, m_valid, "Result beat dropped.")
    `ENB_ASSERT_IMPL(a_no_accept_busy, !(s_ready && state_reg != ST_IDLE), "Ready while busy.")
    `ENB_ASSERT_NEXT(a_out_sets_valid, state_reg == ST_OUT, m_valid, "Result not presented.")
endmodule

[hdl/enb_dp.sv]
`timescale 1ns / 1ps
`include "edge_normalized_image_blur_top_assert.svh"
module enb_dp
    import enb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  enb_in_t             s_data,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_idx,
    input  logic [CfgDataW-1:0] cfg_data,
    input  enb_cmd_t            cmd,
    output enb_sts_t            sts,
    output enb_out_t            m_data
);
    logic [3:0] ksize_reg;
    logic [8:0] width_reg, height_reg;
    logic [2:0] chans_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksize_reg <= 4'd3;
            width_reg <= 9'd256;
            height_reg <= 9'd256;
            chans_reg <= 3'd3;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_KSIZE: ksize_reg <= cfg_data[3:0];
                REG_WIDTH: width_reg <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_CHANS: chans_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    logic [4:0] ks_eff;
    logic [8:0] w_eff, h_eff;
    logic [2:0] nch;
    always_comb begin
        ks_eff = (5'(ksize_reg) > 5'(MaxKernel)) ? 5'(MaxKernel) : 5'(ksize_reg);
        if (ks_eff == 5'd0) ks_eff = 5'd1;
        else if (!ks_eff[0]) ks_eff = ks_eff - 5'd1;
        w_eff = (width_reg == 9'd0) ? 9'd1 : (width_reg > 9'(MaxWidth) ? 9'(MaxWidth) : width_reg);
        h_eff = (height_reg == 9'd0) ? 9'd1 :
                (height_reg > 9'(MaxHeight) ? 9'(MaxHeight) : height_reg);
        nch = (chans_reg == 3'd0) ? 3'd1 : (chans_reg > 3'd4 ? 3'd4 : chans_reg);
    end

    logic [15:0] kw_mem [KwDepth];
    logic [31:0] px_mem [PixDepth];
    logic [15:0] kw_rd_reg;
    logic [31:0] px_rd_reg;
    logic [KwAw-1:0] kw_ra;
    logic [PixAw-1:0] px_ra;

    always_ff @(posedge aclk) begin
        if (cmd.wr_weight && 32'(s_data.index) < KwDepth) begin
            kw_mem[KwAw'(s_data.index)] <= s_data.weight_value;
        end
        if (cmd.wr_pixel && 32'(s_data.index) < PixDepth) begin
            px_mem[PixAw'(s_data.index)] <= {s_data.in_chan3, s_data.in_chan2,
                                             s_data.in_chan1, s_data.in_chan0};
        end
        kw_rd_reg <= kw_mem[kw_ra];
        px_rd_reg <= px_mem[px_ra];
    end

    // Row and column of the request: found by a subtracting sweep, one row per cycle
    // would be long, so a restoring division over 16 quotient bits is used.
    logic [15:0] idx_reg;
    logic [15:0] row_reg;
    logic [4:0]  rc_cnt_reg;
    logic [15:0] rc_rem_reg;
    logic        rc_busy_reg;

    // Window scan counters.
    logic [4:0]  tr_reg, tc_reg;
    logic [7:0]  kidx_reg;
    logic        tap_vld_reg, tap_go_reg;
    logic        acc_en_reg;
    logic        scan_reg;
    logic signed [17:0] rr, cc;
    logic        inb;
    logic [4:0]  rad;

    assign rad = ks_eff >> 1;
    assign rr = $signed({2'b0, row_reg}) + $signed({13'b0, tr_reg}) - $signed({13'b0, rad});
    assign cc = $signed({2'b0, rc_rem_reg}) + $signed({13'b0, tc_reg}) - $signed({13'b0, rad});
    assign inb = (rr >= 0) && (rr < $signed({9'b0, h_eff})) &&
                 (cc >= 0) && (cc < $signed({9'b0, w_eff}));

    logic [25:0] pidx_full;
    assign pidx_full = 26'(rr[15:0]) * 26'(w_eff) + 26'(cc[15:0]);
    assign kw_ra = KwAw'(kidx_reg);
    assign px_ra = PixAw'(pidx_full);
    logic px_oob_d;

    logic [23:0] wsum_reg;
    logic [31:0] csum_reg [4];

    logic last_tap;
    assign last_tap = (tr_reg == ks_eff - 5'd1) && (tc_reg == ks_eff - 5'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_busy_reg <= 1'b0;
            scan_reg <= 1'b0;
            tap_vld_reg <= 1'b0;
            acc_en_reg <= 1'b0;
            tap_go_reg <= 1'b0;
        end else begin
            acc_en_reg <= tap_vld_reg;
            tap_vld_reg <= 1'b0;
            if (cmd.load_req) begin
                idx_reg <= s_data.index;
                rc_rem_reg <= 16'd0;
                row_reg <= s_data.index;
                rc_cnt_reg <= 5'd16;
                rc_busy_reg <= (s_data.mode == MODE_BLUR);
                tap_go_reg <= 1'b0;
            end else if (rc_busy_reg) begin
                // Restoring division of index by width: row_reg holds the quotient bits.
                if ({rc_rem_reg[14:0], row_reg[15]} >= 16'(w_eff)) begin
                    rc_rem_reg <= {rc_rem_reg[14:0], row_reg[15]} - 16'(w_eff);
                    row_reg <= {row_reg[14:0], 1'b1};
                end else begin
                    rc_rem_reg <= {rc_rem_reg[14:0], row_reg[15]};
                    row_reg <= {row_reg[14:0], 1'b0};
                end
                rc_cnt_reg <= rc_cnt_reg - 5'd1;
                if (rc_cnt_reg == 5'd1) begin
                    rc_busy_reg <= 1'b0;
                    tap_go_reg <= 1'b1;
                end
            end
            if (cmd.tap_start) begin
                tr_reg <= 5'd0;
                tc_reg <= 5'd0;
                kidx_reg <= 8'd0;
                scan_reg <= 1'b1;
                wsum_reg <= '0;
                for (int i = 0; i < 4; i++) csum_reg[i] <= '0;
            end else if (cmd.tap_step && scan_reg && tap_go_reg && !rc_busy_reg) begin
                tap_vld_reg <= inb;
                px_oob_d <= (32'(pidx_full) >= PixDepth);
                kidx_reg <= kidx_reg + 8'd1;
                if (tc_reg == ks_eff - 5'd1) begin
                    tc_reg <= 5'd0;
                    tr_reg <= tr_reg + 5'd1;
                end else begin
                    tc_reg <= tc_reg + 5'd1;
                end
                if (last_tap) scan_reg <= 1'b0;
            end
            if (tap_vld_reg) begin
                wsum_reg <= wsum_reg + 24'(kw_rd_reg);
                for (int i = 0; i < 4; i++) begin
                    csum_reg[i] <= csum_reg[i] +
                        (px_oob_d ? 32'd0 : 32'(kw_rd_reg) * 32'(px_rd_reg[8*i +: 8]));
                end
            end
        end
    end

    logic [2:0] drain_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) drain_reg <= '0;
        else drain_reg <= {drain_reg[1:0], scan_reg};
    end
    assign sts.tap_last = !scan_reg && !rc_busy_reg && tap_go_reg && drain_reg == 3'd0
                          && !tap_vld_reg && !acc_en_reg;

    // Restoring divider, one quotient bit per cycle, channels in turn.
    logic [1:0]  dch_reg;
    logic [5:0]  dcnt_reg;
    logic [31:0] dq_reg;
    logic [23:0] drem_reg;
    logic [7:0]  q_reg [4];
    logic [24:0] trial;
    assign trial = {drem_reg, dq_reg[31]};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dch_reg <= 2'd0;
            dcnt_reg <= 6'd32;
            dq_reg <= csum_reg[0];
            drem_reg <= '0;
        end else if (cmd.div_step) begin
            if (dcnt_reg == 6'd0) begin
                q_reg[dch_reg] <= dq_reg[7:0];
                dch_reg <= dch_reg + 2'd1;
                dcnt_reg <= 6'd32;
                dq_reg <= csum_reg[2'(dch_reg + 2'd1)];
                drem_reg <= '0;
            end else begin
                if (trial >= 25'(wsum_reg)) begin
                    drem_reg <= 24'(trial - 25'(wsum_reg));
                    dq_reg <= {dq_reg[30:0], 1'b1};
                end else begin
                    drem_reg <= trial[23:0];
                    dq_reg <= {dq_reg[30:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 6'd1;
            end
        end
    end
    assign sts.div_last = cmd.div_step && dcnt_reg == 6'd0 && dch_reg == 2'd3;

    logic zero_w;
    assign zero_w = (wsum_reg == 24'd0);
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data.pixel_number <= idx_reg;
            m_data.out_chan0 <= (!zero_w) ? q_reg[0] : 8'd0;
            m_data.out_chan1 <= (!zero_w && nch > 3'd1) ? q_reg[1] : 8'd0;
            m_data.out_chan2 <= (!zero_w && nch > 3'd2) ? q_reg[2] : 8'd0;
            m_data.out_chan3 <= (!zero_w && nch > 3'd3) ? q_reg[3] : 8'd0;
            m_data.no_weight_seen <= zero_w;
        end
    end

    `ENB_ASSERT_IMPL(a_kidx_range, !scan_reg || kidx_reg < 8'(KwDepth), "Weight index overrun.")
    `ENB_ASSERT_NEXT(a_div_clear, cmd.div_start, drem_reg == 24'd0, "Divider not cleared.")
    `ENB_ASSERT_IMPL(a_rc_excl, !(rc_busy_reg && scan_reg && tap_vld_reg), "Scan before row known.")
endmodule

[hdl/edge_normalized_image_blur_top.sv]
`timescale 1ns / 1ps
// Channel   Ports                          Carries
// s_        s_valid, s_ready, s_data       one input beat (load weight, load pixel, request)
// m_        m_valid, m_ready, m_data       one blurred pixel per request
// cfg_      cfg_we, cfg_idx, cfg_data      register writes
// Load beats can follow back to back while the block is idle. A request splits the
// pixel number into row and column, steps through the window one tap at a time, drains
// the tap pipeline and starts the divider, passes each channel in turn through the
// shared bit-serial divider and loads the result; the next beat can be taken in the
// same cycle as the result is presented. Reset is synchronous and active low and clears
// control state; the memories are not cleared. A result that is not taken stalls the
// next request at its output stage, and no further beat is taken until it leaves that stage.
module edge_normalized_image_blur_top
    import enb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  enb_in_t             s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output enb_out_t            m_data,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_idx,
    input  logic [CfgDataW-1:0] cfg_data
);
    enb_cmd_t cmd;
    enb_sts_t sts;

    enb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_data.mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    enb_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .m_data   (m_data)
    );
endmodule

[verif/edge_normalized_image_blur_checker.sv]
`timescale 1ns / 1ps
module edge_normalized_image_blur_checker
    import enb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  enb_in_t             s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  enb_out_t            m_data,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_idx,
    input  logic [CfgDataW-1:0] cfg_data,
    output int                  errors,
    output int                  pending,
    output int                  results
);
    logic [15:0] kernel_mem [KwDepth];
    logic [31:0] image_mem [PixDepth];
    logic [3:0]  ksize_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [2:0]  chans_reg;
    enb_out_t    blurred_q [$];

    initial begin
        errors = 0;
        pending = 0;
        results = 0;
    end

    function automatic int clip_dim(int v, int maxv);
        if (v == 0) begin
            return 1;
        end
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic enb_out_t blur_at(logic [15:0] pnum);
        int w, h, nch, side, rad, row, col, rr, cc, kidx, pidx;
        longint unsigned wsum;
        longint unsigned csum [4];
        longint unsigned quo;
        logic [15:0] wt;
        logic [31:0] px;
        logic [7:0]  chan [4];
        enb_out_t    res;
        w = clip_dim(width_reg, MaxWidth);
        h = clip_dim(height_reg, MaxHeight);
        nch = clip_dim(chans_reg, 4);
        side = (ksize_reg > MaxKernel) ? MaxKernel : ksize_reg;
        if (side == 0) begin
            side = 1;
        end else if (side % 2 == 0) begin
            side = side - 1;
        end
        rad = side / 2;
        row = pnum / w;
        col = pnum % w;
        wsum = 0;
        for (int c = 0; c < 4; c++) begin
            csum[c] = 0;
        end
        for (int dr = -rad; dr <= rad; dr++) begin
            for (int dc = -rad; dc <= rad; dc++) begin
                rr = row + dr;
                cc = col + dc;
                if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
                    kidx = (dr + rad) * side + (dc + rad);
                    wt = (kidx < KwDepth) ? kernel_mem[KwAw'(kidx)] : 16'd0;
                    wsum += wt;
                    pidx = rr * w + cc;
                    px = (pidx < PixDepth) ? image_mem[PixAw'(pidx)] : 32'd0;
                    for (int c = 0; c < nch; c++) begin
                        csum[c] += longint'(wt) * longint'(px[8*c +: 8]);
                    end
                end
            end
        end
        for (int c = 0; c < 4; c++) begin
            quo = (c < nch && wsum != 0) ? csum[c] / wsum : 0;
            chan[c] = quo[7:0];
        end
        res.pixel_number = pnum;
        res.out_chan0 = chan[0];
        res.out_chan1 = chan[1];
        res.out_chan2 = chan[2];
        res.out_chan3 = chan[3];
        res.no_weight_seen = (wsum == 0);
        return res;
    endfunction

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        enb_out_t want;
        if (!aresetn) begin
            ksize_reg = 4'd3;
            width_reg = 9'd256;
            height_reg = 9'd256;
            chans_reg = 3'd3;
            blurred_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_KSIZE:  ksize_reg = cfg_data[3:0];
                    REG_WIDTH:  width_reg = cfg_data[8:0];
                    REG_HEIGHT: height_reg = cfg_data[8:0];
                    REG_CHANS:  chans_reg = cfg_data[2:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_data.mode)
                    MODE_WEIGHT: begin
                        if (s_data.index < KwDepth) begin
                            kernel_mem[KwAw'(s_data.index)] = s_data.weight_value;
                        end
                    end
                    MODE_PIXEL: begin
                        if (s_data.index < PixDepth) begin
                            image_mem[PixAw'(s_data.index)] = {s_data.in_chan3,
                                                               s_data.in_chan2,
                                                               s_data.in_chan1,
                                                               s_data.in_chan0};
                        end
                    end
                    MODE_BLUR: blurred_q.push_back(blur_at(s_data.index));
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results++;
                if (blurred_q.size() == 0) begin
                    $error("result beat for pixel %0d with nothing expected",
                           m_data.pixel_number);
                    errors++;
                end else begin
                    want = blurred_q.pop_front();
                    check_field("pixel_number", want.pixel_number, m_data.pixel_number);
                    check_field("out_chan0", want.out_chan0, m_data.out_chan0);
                    check_field("out_chan1", want.out_chan1, m_data.out_chan1);
                    check_field("out_chan2", want.out_chan2, m_data.out_chan2);
                    check_field("out_chan3", want.out_chan3, m_data.out_chan3);
                    check_field("no_weight_seen", want.no_weight_seen, m_data.no_weight_seen);
                end
            end
        end
        pending <= blurred_q.size();
    end
endmodule

[verif/edge_normalized_image_blur_top_test.sv]
`timescale 1ns / 1ps
module edge_normalized_image_blur_top_test;
    import enb_pkg::*;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int ItemTarget = 1700;
    localparam int CalmFrom = 1500;
    localparam int StallLimit = 4000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    enb_in_t             s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    enb_out_t            m_data;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_idx = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    int                  errors, pending, results;

    bit pix_loaded [PixDepth];
    bit kw_loaded [KwDepth];
    int side_eff = 3;
    int width_eff = 256;
    int height_eff = 256;
    int sent = 0;
    int requests = 0;
    bit calm = 1'b0;
    int stall_cycles = 0;

    edge_normalized_image_blur_top DUT (.*);

    edge_normalized_image_blur_checker checker_inst (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == StallLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            if (!calm) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
        end
    end

    function automatic int clip_dim(int v, int maxv);
        if (v == 0) begin
            return 1;
        end
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic bit window_loaded(int pnum);
        int rad, row, col, rr, cc;
        rad = side_eff / 2;
        row = pnum / width_eff;
        col = pnum % width_eff;
        for (int dr = -rad; dr <= rad; dr++) begin
            for (int dc = -rad; dc <= rad; dc++) begin
                rr = row + dr;
                cc = col + dc;
                if (rr >= 0 && rr < height_eff && cc >= 0 && cc < width_eff) begin
                    if (!pix_loaded[PixAw'(rr * width_eff + cc)]) begin
                        return 1'b0;
                    end
                    if (!kw_loaded[KwAw'((dr + rad) * side_eff + dc + rad)]) begin
                        return 1'b0;
                    end
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic enb_in_t make_beat(logic [1:0] mode, int index);
        enb_in_t beat;
        beat.mode = mode;
        beat.index = index[15:0];
        beat.weight_value = 16'($urandom_range(0, 65535));
        beat.in_chan0 = 8'($urandom_range(0, 255));
        beat.in_chan1 = 8'($urandom_range(0, 255));
        beat.in_chan2 = 8'($urandom_range(0, 255));
        beat.in_chan3 = 8'($urandom_range(0, 255));
        return beat;
    endfunction

    task automatic send_beat(enb_in_t beat);
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (beat.mode == MODE_PIXEL && beat.index < PixDepth) begin
            pix_loaded[PixAw'(beat.index)] = 1'b1;
        end
        if (beat.mode == MODE_WEIGHT && beat.index < KwDepth) begin
            kw_loaded[KwAw'(beat.index)] = 1'b1;
        end
        if (beat.mode == MODE_BLUR) begin
            requests++;
        end
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    task automatic request_blur(int pnum);
        if (pnum >= 0 && pnum < 65536 && window_loaded(pnum)) begin
            send_beat(make_beat(MODE_BLUR, pnum));
        end
    endtask

    task automatic load_patch(int r0, int c0, int span);
        for (int r = r0 - span; r <= r0 + span; r++) begin
            for (int c = c0 - span; c <= c0 + span; c++) begin
                if (r >= 0 && r < height_eff && c >= 0 && c < width_eff) begin
                    send_beat(make_beat(MODE_PIXEL, r * width_eff + c));
                end
            end
        end
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_config(int ksize, int width, int height, int chans);
        int s;
        cfg_we <= 1'b1;
        cfg_idx <= REG_KSIZE;
        cfg_data <= CfgDataW'(ksize);
        @(posedge aclk);
        cfg_idx <= REG_WIDTH;
        cfg_data <= CfgDataW'(width);
        @(posedge aclk);
        cfg_idx <= REG_HEIGHT;
        cfg_data <= CfgDataW'(height);
        @(posedge aclk);
        cfg_idx <= REG_CHANS;
        cfg_data <= CfgDataW'(chans);
        @(posedge aclk);
        cfg_we <= 1'b0;
        s = (ksize > MaxKernel) ? MaxKernel : ksize;
        side_eff = (s == 0) ? 1 : ((s % 2 == 0) ? s - 1 : s);
        width_eff = clip_dim(width, MaxWidth);
        height_eff = clip_dim(height, MaxHeight);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 256;
            3: return $urandom_range(257, 511);
            default: return $urandom_range(2, 40);
        endcase
    endfunction

    function automatic int pick_ksize();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return $urandom_range(1, 5);
        end else if (r < 9) begin
            return $urandom_range(0, 11);
        end
        return $urandom_range(12, 15);
    endfunction

    task automatic random_phase;
        int r0, c0, span, rad, n, pick, rr, cc, area;
        enb_in_t beat;
        set_config(pick_ksize(), pick_dim(), pick_dim(), $urandom_range(0, 7));
        rad = side_eff / 2;
        r0 = ($urandom_range(0, 1) == 0) ? $urandom_range(0, height_eff - 1)
                                         : (($urandom_range(0, 1) == 0) ? 0 : height_eff - 1);
        c0 = ($urandom_range(0, 1) == 0) ? $urandom_range(0, width_eff - 1)
                                         : (($urandom_range(0, 1) == 0) ? 0 : width_eff - 1);
        span = rad + 1;
        load_patch(r0, c0, span);
        n = (side_eff >= 11) ? 15 : 50;
        area = width_eff * height_eff;
        repeat (n) begin
            if (sent >= CalmFrom) begin
                calm = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                rr = r0 + $urandom_range(0, 2 * span) - span;
                cc = c0 + $urandom_range(0, 2 * span) - span;
                if (rr >= 0 && cc >= 0 && cc < width_eff) begin
                    request_blur(rr * width_eff + cc);
                end
            end else if (pick < 75) begin
                rr = r0 + $urandom_range(0, 2 * span) - span;
                cc = c0 + $urandom_range(0, 2 * span) - span;
                if (rr >= 0 && rr < height_eff && cc >= 0 && cc < width_eff) begin
                    send_beat(make_beat(MODE_PIXEL, rr * width_eff + cc));
                end
            end else if (pick < 85) begin
                beat = make_beat(MODE_WEIGHT, $urandom_range(0, KwDepth - 1));
                if ($urandom_range(0, 9) == 0) begin
                    beat.weight_value = 16'd0;
                end
                send_beat(beat);
            end else if (pick < 95) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_beat(make_beat(MODE_IGNORED, $urandom_range(0, 65535)));
                end else begin
                    send_beat(make_beat(MODE_WEIGHT, $urandom_range(KwDepth, 65535)));
                end
            end else if (area < 65536) begin
                request_blur($urandom_range(area, 65535));
            end
        end
        drain();
    endtask

    initial begin
        enb_in_t beat;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < KwDepth; i++) begin
            beat = make_beat(MODE_WEIGHT, i);
            if (i == 4) begin
                beat.weight_value = 16'hFFFF;
            end
            send_beat(beat);
        end
        drain();

        set_config(3, 256, 256, 4);
        load_patch(0, 0, 2);
        load_patch(255, 255, 2);
        beat = make_beat(MODE_PIXEL, 1);
        {beat.in_chan0, beat.in_chan1, beat.in_chan2, beat.in_chan3} = '1;
        send_beat(beat);
        beat = make_beat(MODE_PIXEL, 256);
        {beat.in_chan0, beat.in_chan1, beat.in_chan2, beat.in_chan3} = '0;
        send_beat(beat);
        request_blur(0);
        request_blur(65535);
        request_blur(257);
        send_beat(make_beat(MODE_IGNORED, 0));
        send_beat(make_beat(MODE_WEIGHT, 65535));
        drain();

        // With a single tap of weight zero the sum of weights is zero.
        set_config(1, 256, 256, 2);
        beat = make_beat(MODE_WEIGHT, 0);
        beat.weight_value = 16'd0;
        send_beat(beat);
        request_blur(0);
        drain();
        // A one-pixel image and a request far outside it: no tap lies inside.
        set_config(0, 1, 1, 7);
        request_blur(65535);
        request_blur(0);
        beat = make_beat(MODE_WEIGHT, 0);
        beat.weight_value = 16'd1234;
        send_beat(beat);
        drain();

        while (sent < ItemTarget) begin
            random_phase();
        end
        set_config(15, 256, 256, 4);
        load_patch(0, 0, 8);
        request_blur(0);
        request_blur(257);
        drain();
        repeat (400) @(posedge aclk);

        $display("Sent %0d input beats, %0d of them blur requests; checked %0d results.",
                 sent, requests, results);
        $display("Configurations ranged over kernel sizes 0 to 15 and image sides 0 to 511.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
